@@ hdl/lmss_pkg.sv @@
// Shared constants and types for the LED matrix scroll scanner.
`timescale 1ns / 1ps

package lmss_pkg;

    // Default geometry of the glyph store.
    localparam int DEF_MAX_CHARS  = 32;
    localparam int DEF_GLYPH_ROWS = 7;

    // Fixed matrix width and field widths.
    localparam int GLYPH_COLUMNS = 5;
    localparam int ROW_BITS_W    = 5;
    localparam int OP_W          = 2;
    localparam int SLOT_IN_W     = 5;
    localparam int ROW_IN_W      = 3;
    localparam int COL_W         = 3;
    localparam int HOLD_W        = 16;
    localparam int TEXT_LEN_W    = 6;
    localparam int BRIGHT_W      = 8;
    localparam int CFG_DATA_W    = 8;
    localparam int CFG_IDX_W     = 1;

    // Operation codes of an input word.
    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_SCROLL = 2'd1,
        OP_SHIFT  = 2'd2
    } op_t;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS  = 1'b1;

    // Reset hold time is the square of the reset brightness of 16.
    localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd256;

endpackage

@@ hdl/led_matrix_scroll_scanner.sv @@
// Column-major LED matrix scanner with a glyph memory and a scroll offset.
// A shift word's result is registered in front of the memory, then in the output stage.
// Throughput: one word per cycle while the output takes words and no rebase runs;
// the glyph memory is read once per bit. A text_length write stalls the input
// while a remainder unit rebases the slot and offset to the new length.
// Reset clears the scan counters, scroll offset and pending scroll, sets length 1
// and brightness 16; the glyph memory is not cleared and must be loaded first.
`timescale 1ns / 1ps

module led_matrix_scroll_scanner #(
    parameter int MAX_CHARS  = lmss_pkg::DEF_MAX_CHARS,
    parameter int GLYPH_ROWS = lmss_pkg::DEF_GLYPH_ROWS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration write port
    input  logic                              cfg_wr_en,
    input  logic [lmss_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lmss_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    // Input channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [lmss_pkg::OP_W-1:0]         s_operation,
    input  logic [lmss_pkg::SLOT_IN_W-1:0]    s_char_slot,
    input  logic [lmss_pkg::ROW_IN_W-1:0]     s_glyph_row,
    input  logic [lmss_pkg::ROW_BITS_W-1:0]   s_row_bits,
    // Result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_data_bit,
    output logic                              m_column_strobe,
    output logic [lmss_pkg::COL_W-1:0]        m_column_index,
    output logic [lmss_pkg::HOLD_W-1:0]       m_hold_us,
    output logic                              m_frame_last
);

    import lmss_pkg::*;

    localparam int SLOT_W = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
    localparam int LEN_W  = $clog2(MAX_CHARS + 1);
    localparam int ROW_W  = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;
    localparam int DEPTH  = MAX_CHARS * GLYPH_ROWS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int STEP_W = (SLOT_W > 1) ? $clog2(SLOT_W) : 1;
    localparam int NORM_W = LEN_W + SLOT_W;
    localparam int CNT_W  = LEN_W + 1;

    localparam logic [LEN_W-1:0]  MAX_LEN    = LEN_W'(MAX_CHARS);
    localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(GLYPH_ROWS - 1);
    localparam logic [COL_W-1:0]  COL_LAST   = COL_W'(GLYPH_COLUMNS - 1);
    localparam logic [STEP_W-1:0] STEP_FIRST = STEP_W'(SLOT_W - 1);

    // Configuration and scan state
    logic [LEN_W-1:0]      len_reg;
    logic [HOLD_W-1:0]     hold_reg;
    logic [SLOT_W-1:0]     off_raw_reg;
    logic [SLOT_W-1:0]     off_mod_reg;
    logic [SLOT_W-1:0]     slot_raw_reg;
    logic [SLOT_W-1:0]     slot_mod_reg;
    logic [ROW_W-1:0]      row_reg;
    logic [COL_W-1:0]      col_reg;
    logic                  pend_reg;

    // Remainder unit that rebases slot and offset after a length change
    logic                  busy_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [SLOT_W-1:0]     w_slot_reg;
    logic [SLOT_W-1:0]     w_off_reg;
    logic [SLOT_W-1:0]     w_slot_next;
    logic [SLOT_W-1:0]     w_off_next;
    logic [NORM_W-1:0]     trial;

    // Pipeline stage in front of the memory
    logic                  s1_valid_reg;
    logic                  s1_shift_reg;
    logic [ADDR_W-1:0]     s1_addr_reg;
    logic [ROW_BITS_W-1:0] s1_wdata_reg;
    logic [COL_W-1:0]      s1_col_reg;
    logic                  s1_strobe_reg;
    logic                  s1_last_reg;

    // Output stage, fed by the memory read
    logic                  s2_valid_reg;
    logic [COL_W-1:0]      s2_col_reg;
    logic                  s2_strobe_reg;
    logic                  s2_last_reg;
    logic [ROW_BITS_W-1:0] rd_reg;

    logic [ROW_BITS_W-1:0] glyph_mem [DEPTH];

    // Handshake and pipeline movement
    logic                  adv;
    logic                  s1_go;
    logic                  s_fire;
    logic                  load_ok;
    logic                  fire_load;
    logic                  fire_scroll;
    logic                  fire_shift;

    // Scan arithmetic
    logic                  frame_start;
    logic [CNT_W-1:0]      off_inc;
    logic [SLOT_W-1:0]     off_step;
    logic [SLOT_W-1:0]     off_use;
    logic [CNT_W-1:0]      ch_sum;
    logic [SLOT_W-1:0]     ch;
    logic                  row_end;
    logic [CNT_W-1:0]      slot_inc;
    logic                  slot_end;
    logic                  col_end;
    logic [ADDR_W-1:0]     rd_addr;
    logic [ADDR_W-1:0]     wr_addr;

    // Configuration decode
    logic [TEXT_LEN_W-1:0] text_len;
    logic [LEN_W-1:0]      len_clamped;
    logic [BRIGHT_W-1:0]   bright;
    logic [HOLD_W-1:0]     hold_next;

    // The pipeline moves whenever the output stage is free or being taken.
    assign adv     = !s2_valid_reg || m_ready;
    assign s1_go   = s1_valid_reg && adv;
    assign s_ready = !busy_reg && (!s1_valid_reg || adv);
    assign s_fire  = s_valid && s_ready;

    // Decode the accepted word.
    always_comb begin
        load_ok = (32'(s_char_slot) < MAX_CHARS) && (32'(s_glyph_row) < GLYPH_ROWS);
        fire_load   = 1'b0;
        fire_scroll = 1'b0;
        fire_shift  = 1'b0;
        case (op_t'(s_operation))
            OP_LOAD:   fire_load   = s_fire && load_ok;
            OP_SCROLL: fire_scroll = s_fire;
            OP_SHIFT:  fire_shift  = s_fire;
            default:   ;
        endcase
    end

    // Clamp the text length and square the brightness for the hold time.
    always_comb begin
        text_len = cfg_wr_data[TEXT_LEN_W-1:0];
        if (text_len == '0) begin
            len_clamped = LEN_W'(1);
        end else if (32'(text_len) > MAX_CHARS) begin
            len_clamped = MAX_LEN;
        end else begin
            len_clamped = LEN_W'(text_len);
        end
        bright    = cfg_wr_data[BRIGHT_W-1:0];
        hold_next = HOLD_W'(bright) * HOLD_W'(bright);
    end

    // One restoring remainder step per cycle on both working values.
    always_comb begin
        trial = NORM_W'(len_reg) << step_reg;
        if (NORM_W'(w_slot_reg) >= trial) begin
            w_slot_next = SLOT_W'(NORM_W'(w_slot_reg) - trial);
        end else begin
            w_slot_next = w_slot_reg;
        end
        if (NORM_W'(w_off_reg) >= trial) begin
            w_off_next = SLOT_W'(NORM_W'(w_off_reg) - trial);
        end else begin
            w_off_next = w_off_reg;
        end
    end

    // Character index, memory addresses and counter wrap conditions.
    // Slot and offset are both kept below the length, so one subtract wraps the sum.
    always_comb begin
        frame_start = (col_reg == '0) && (slot_raw_reg == '0) && (row_reg == '0) && pend_reg;
        off_inc     = CNT_W'(off_mod_reg) + CNT_W'(1);
        off_step    = (off_inc == CNT_W'(len_reg)) ? '0 : SLOT_W'(off_inc);
        off_use     = frame_start ? off_step : off_mod_reg;
        ch_sum      = CNT_W'(slot_mod_reg) + CNT_W'(off_use);
        if (ch_sum >= CNT_W'(len_reg)) begin
            ch = SLOT_W'(ch_sum - CNT_W'(len_reg));
        end else begin
            ch = SLOT_W'(ch_sum);
        end
        rd_addr  = ADDR_W'(32'(ch) * GLYPH_ROWS + 32'(row_reg));
        wr_addr  = ADDR_W'(32'(s_char_slot) * GLYPH_ROWS + 32'(s_glyph_row));
        row_end  = (row_reg == ROW_LAST);
        slot_inc = CNT_W'(slot_raw_reg) + CNT_W'(1);
        slot_end = row_end && (slot_inc >= CNT_W'(len_reg));
        col_end  = slot_end && (col_reg == COL_LAST);
    end

    // Configuration, scan counters, scroll offset and the remainder unit.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg      <= LEN_W'(1);
            hold_reg     <= HOLD_RESET;
            off_raw_reg  <= '0;
            off_mod_reg  <= '0;
            slot_raw_reg <= '0;
            slot_mod_reg <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
            pend_reg     <= 1'b0;
            busy_reg     <= 1'b0;
            step_reg     <= '0;
            w_slot_reg   <= '0;
            w_off_reg    <= '0;
        end else begin
            if (fire_scroll) begin
                pend_reg <= 1'b1;
            end
            if (fire_shift) begin
                if (frame_start) begin
                    off_raw_reg <= off_step;
                    off_mod_reg <= off_step;
                    pend_reg    <= 1'b0;
                end
                if (row_end) begin
                    row_reg <= '0;
                    if (slot_end) begin
                        slot_raw_reg <= '0;
                        slot_mod_reg <= '0;
                        col_reg      <= col_end ? '0 : col_reg + COL_W'(1);
                    end else begin
                        slot_raw_reg <= SLOT_W'(slot_inc);
                        slot_mod_reg <= slot_mod_reg + SLOT_W'(1);
                    end
                end else begin
                    row_reg <= row_reg + ROW_W'(1);
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_TEXT_LENGTH: begin
                        len_reg    <= len_clamped;
                        busy_reg   <= 1'b1;
                        step_reg   <= STEP_FIRST;
                        w_slot_reg <= slot_raw_reg;
                        w_off_reg  <= off_raw_reg;
                    end
                    REG_BRIGHTNESS: begin
                        hold_reg <= hold_next;
                    end
                    default: ;
                endcase
            end
            // A brightness write does not hold back the remainder steps.
            if (busy_reg && !(cfg_wr_en && (cfg_index == REG_TEXT_LENGTH))) begin
                w_slot_reg <= w_slot_next;
                w_off_reg  <= w_off_next;
                step_reg   <= step_reg - STEP_W'(1);
                if (step_reg == '0) begin
                    busy_reg     <= 1'b0;
                    slot_mod_reg <= w_slot_next;
                    off_mod_reg  <= w_off_next;
                end
            end
        end
    end

    // Pipeline valid flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            if (s_ready || adv) begin
                s1_valid_reg <= fire_load || fire_shift;
            end
            if (adv) begin
                s2_valid_reg <= s1_valid_reg && s1_shift_reg;
            end
        end
    end

    // Pipeline payload.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_shift_reg  <= fire_shift;
            s1_addr_reg   <= fire_shift ? rd_addr : wr_addr;
            s1_wdata_reg  <= s_row_bits;
            s1_col_reg    <= col_reg;
            s1_strobe_reg <= slot_end;
            s1_last_reg   <= col_end;
        end
        if (s1_go && s1_shift_reg) begin
            s2_col_reg    <= s1_col_reg;
            s2_strobe_reg <= s1_strobe_reg;
            s2_last_reg   <= s1_last_reg;
        end
    end

    // Glyph memory: loads and reads leave the same stage in order.
    always_ff @(posedge aclk) begin
        if (s1_go && !s1_shift_reg) begin
            glyph_mem[s1_addr_reg] <= s1_wdata_reg;
        end
        if (s1_go && s1_shift_reg) begin
            rd_reg <= glyph_mem[s1_addr_reg];
        end
    end

    // Result word.
    assign m_valid         = s2_valid_reg;
    assign m_data_bit      = (32'(s2_col_reg) < ROW_BITS_W) ? rd_reg[s2_col_reg] : 1'b0;
    assign m_column_strobe = s2_strobe_reg;
    assign m_column_index  = s2_col_reg;
    assign m_hold_us       = s2_strobe_reg ? hold_reg : '0;
    assign m_frame_last    = s2_last_reg;

`ifndef SYNTHESIS
    // A length write stops input while the remainder unit runs.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_wr_en && (cfg_index == REG_TEXT_LENGTH)) |=> !s_ready)
        else $error("input accepted right after a length write");

    // Outside a rebase the slot and offset stay below the length.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> ((LEN_W'(slot_mod_reg) < len_reg) && (LEN_W'(off_mod_reg) < len_reg)))
        else $error("slot or offset not reduced below the length");

    // The last bit of a frame always ends a column.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_frame_last) |-> m_column_strobe)
        else $error("frame end without a column strobe");

    // A word stalled at the output keeps its strobe and column.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_column_index) && $stable(m_column_strobe)))
        else $error("stalled result word changed");
`endif

endmodule
